FILE: rtl/imf_pkg.sv
// ----------------------------------------------------------------------------
// imf_pkg - shared types and constants of the image median filter
// Pixel and window types, register indexes, input action codes and the
// fixed sizes of the window and the output queue.
// ----------------------------------------------------------------------------
package imf_pkg;

    localparam int PIX_W        = 8;
    localparam int WIN_SIZE     = 3;
    localparam int WIN_COUNT    = WIN_SIZE * WIN_SIZE;
    localparam int WIN_MID      = WIN_COUNT / 2;

    // Line store slots: one row per slot, row r lives in slot r mod 4.
    localparam int STORE_ROWS   = 4;
    localparam int SLOT_W       = 2;

    // Configuration port.
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_FLD_W  = 11;
    localparam int HEIGHT_W     = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Input actions.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Output queue.
    localparam int OFIFO_DEPTH  = 16;
    localparam int OFIFO_AW     = 4;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef t_pix [WIN_COUNT-1:0]     t_win;
    typedef t_pix [WIN_SIZE-1:0]      t_col;

    typedef struct packed {
        logic valid;
        logic last;
    } t_cell_ctl;

    typedef struct packed {
        logic              emit;
        logic              pre;
        logic              edge_l;
        logic              edge_r;
        logic              last;
        logic [SLOT_W-1:0] slot_top;
        logic [SLOT_W-1:0] slot_mid;
        logic [SLOT_W-1:0] slot_bot;
        logic              byp;
        logic [SLOT_W-1:0] byp_slot;
    } t_fetch_ctl;

    typedef struct packed {
        t_pix pix;
        logic last;
    } t_out;

endpackage

FILE: rtl/imf_ram.sv
// ----------------------------------------------------------------------------
// imf_ram - generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module imf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/imf_sort_cell.sv
// ----------------------------------------------------------------------------
// imf_sort_cell - one stage of the odd-even transposition sorter
// Compares and swaps neighbouring pairs of the window, starting at the
// element given by PHASE, and hands the result to the next cell.
// ----------------------------------------------------------------------------
module imf_sort_cell
    import imf_pkg::*;
#(
    parameter int PHASE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_win      i_data,
    output t_cell_ctl o_ctl,
    output t_win      o_data
);

    t_cell_ctl r_ctl;
    t_win      r_data;
    t_win      n_data;

    always_comb begin
        n_data = i_data;
        for (int k = PHASE; k + 1 < WIN_COUNT; k += 2) begin
            if (i_data[k] > i_data[k+1]) begin
                n_data[k]   = i_data[k+1];
                n_data[k+1] = i_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;

endmodule

FILE: rtl/image_median_filter_core.sv
// ----------------------------------------------------------------------------
// image_median_filter_core - streaming 3x3 median filter
// Raster-order grey pixels in, median of the mirrored window out, with the
// last result of each frame flagged.
// ----------------------------------------------------------------------------
// The block takes one item per clock, with no gaps, for as long as its output
// queue has room: each item is either a pixel of the frame or, once the whole
// frame is in, a drain step. A result released by an item passes through the
// line store read, the window assembly and the chain of nine sort cells, and
// the middle element of the sorted window is then written to the output queue.
// Results are held in a sixteen-entry queue, and the input stall rises only
// when sixteen results are in flight or waiting, so a stalled consumer lets
// that many be released before the source is held. A result is released by
// the pixel one row below it and one column to its right; after the last
// pixel, as many drain items as the width plus one push out the rest, and the
// final one carries frame_end. A configuration write restarts the frame and
// must only be made while the block is idle. The line store holds four rows of
// MAX_WIDTH pixels in four memories and needs no clearing after reset.
// ----------------------------------------------------------------------------
module image_median_filter_core
    import imf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [PIX_W-1:0]      i_pixel_in,
    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int GW = WW + 1;
    localparam int CW = OFIFO_AW + 1;

    // ------------------------------------------------------------------
    // Configuration registers. Out-of-range values are clamped.
    // ------------------------------------------------------------------
    logic [WW-1:0]          r_width;
    logic [HEIGHT_W-1:0]    r_height;
    logic [WIDTH_FLD_W-1:0] cfg_w_raw;
    logic [HEIGHT_W-1:0]    cfg_h_raw;
    logic [WW-1:0]          cfg_w;
    logic [HEIGHT_W-1:0]    cfg_h;

    assign cfg_w_raw = i_cfg_data[WIDTH_FLD_W-1:0];
    assign cfg_h_raw = i_cfg_data[HEIGHT_W-1:0];

    always_comb begin
        if (32'(cfg_w_raw) < 32'd2) begin
            cfg_w = WW'(2);
        end else if (32'(cfg_w_raw) > 32'(MAX_WIDTH)) begin
            cfg_w = WW'(MAX_WIDTH);
        end else begin
            cfg_w = WW'(cfg_w_raw);
        end
        if (cfg_h_raw < HEIGHT_W'(2)) begin
            cfg_h = HEIGHT_W'(2);
        end else if (32'(cfg_h_raw) > 32'(MAX_HEIGHT)) begin
            cfg_h = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            cfg_h = cfg_h_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(RESET_WIDTH);
            r_height <= HEIGHT_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= cfg_w;
                REG_IMAGE_HEIGHT: r_height <= cfg_h;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position tracking, line store write and window column fetch.
    // r_gap counts pixels written but not yet released as results.
    // ------------------------------------------------------------------
    logic [AW-1:0]       r_in_col, r_out_col;
    logic [HEIGHT_W-1:0] r_in_row, r_out_row;
    logic [GW-1:0]       r_gap;
    logic [CW-1:0]       r_pending;

    logic in_acc, is_pix, complete, wr, take, emit, pre;
    logic in_col_last, in_row_last, complete2;
    logic out_col_last, out_row_last, out_last;
    logic [GW-1:0]       gap2, lag;
    logic [AW-1:0]       fetch_col;
    logic [HEIGHT_W-1:0] fetch_row;
    logic                fr_top, fr_bot;
    t_fetch_ctl          n_fctl, r_fctl;
    t_pix                r_byp_pix;

    assign in_acc       = i_in_valid && !o_in_stall;
    assign is_pix       = (i_action == ACT_PIXEL);
    assign complete     = (r_in_row >= r_height);
    assign wr           = in_acc && is_pix && !complete;
    assign take         = in_acc && (is_pix ? !complete : (i_action == ACT_DRAIN) && complete);
    assign in_col_last  = (WW'(r_in_col) == r_width - WW'(1));
    assign in_row_last  = (r_in_row == r_height - HEIGHT_W'(1));
    assign complete2    = complete || (wr && in_col_last && in_row_last);
    assign gap2         = r_gap + (wr ? GW'(1) : GW'(0));
    assign lag          = GW'(r_width) + GW'(2);
    assign emit         = take && (complete2 || gap2 >= lag);
    assign out_col_last = (WW'(r_out_col) == r_width - WW'(1));
    assign out_row_last = (r_out_row == r_height - HEIGHT_W'(1));
    assign out_last     = out_col_last && out_row_last;

    // Before the first result of a frame the leftmost column is preloaded.
    assign pre = wr && !emit && (r_out_col == '0) && (r_out_row == '0);

    // The column fetched is the right-hand one of the window; at the end of
    // a row it is the first column of the next row's window instead.
    assign fetch_col = (emit && !out_col_last) ? r_out_col + AW'(1) : '0;
    assign fetch_row = (emit && out_col_last) ? r_out_row + HEIGHT_W'(1) : r_out_row;
    assign fr_top    = (fetch_row == '0);
    assign fr_bot    = (fetch_row == r_height - HEIGHT_W'(1));

    always_comb begin
        n_fctl          = '0;
        n_fctl.emit     = emit;
        n_fctl.pre      = pre;
        n_fctl.edge_l   = (r_out_col == '0);
        n_fctl.edge_r   = out_col_last;
        n_fctl.last     = out_last;
        // Rows above the top and below the bottom mirror to the inner row.
        n_fctl.slot_mid = fetch_row[SLOT_W-1:0];
        n_fctl.slot_top = fr_top ? SLOT_W'(1) : fetch_row[SLOT_W-1:0] - SLOT_W'(1);
        n_fctl.slot_bot = fr_bot ? fetch_row[SLOT_W-1:0] - SLOT_W'(1)
                                 : fetch_row[SLOT_W-1:0] + SLOT_W'(1);
        // The pixel written now may be the one being read in the same cycle.
        n_fctl.byp      = wr && (r_in_col == fetch_col);
        n_fctl.byp_slot = r_in_row[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_gap     <= '0;
        end else if (i_cfg_we) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_gap     <= '0;
        end else if (emit && out_last) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_gap     <= '0;
        end else begin
            if (wr) begin
                if (in_col_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + HEIGHT_W'(1);
                end else begin
                    r_in_col <= r_in_col + AW'(1);
                end
            end
            if (emit) begin
                r_gap <= gap2 - GW'(1);
                if (out_col_last) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + HEIGHT_W'(1);
                end else begin
                    r_out_col <= r_out_col + AW'(1);
                end
            end else begin
                r_gap <= gap2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fctl <= '0;
        end else begin
            r_fctl <= in_acc ? n_fctl : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_pix <= i_pixel_in;
    end

    // Line store: four row memories, all read at the fetched column.
    t_pix ram_q [STORE_ROWS];

    for (genvar s = 0; s < STORE_ROWS; s++) begin : g_store
        imf_ram #(
            .WIDTH (PIX_W),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr && (r_in_row[SLOT_W-1:0] == SLOT_W'(s))),
            .i_waddr (r_in_col),
            .i_wdata (i_pixel_in),
            .i_raddr (fetch_col),
            .o_rdata (ram_q[s])
        );
    end

    // ------------------------------------------------------------------
    // Stage 1: new column, column registers and window assembly.
    // ------------------------------------------------------------------
    t_pix      qb [STORE_ROWS];
    t_col      col_n, col_l, col_r;
    t_col      r_col_a, r_col_b;
    t_win      r_win;
    t_cell_ctl r_win_ctl;

    always_comb begin
        for (int s = 0; s < STORE_ROWS; s++) begin
            qb[s] = (r_fctl.byp && r_fctl.byp_slot == SLOT_W'(s)) ? r_byp_pix : ram_q[s];
        end
        col_n[0] = qb[r_fctl.slot_top];
        col_n[1] = qb[r_fctl.slot_mid];
        col_n[2] = qb[r_fctl.slot_bot];
        // Columns left of the first and right of the last mirror inwards.
        if (r_fctl.edge_r) begin
            col_l = r_col_a;
            col_r = r_col_a;
        end else if (r_fctl.edge_l) begin
            col_l = col_n;
            col_r = col_n;
        end else begin
            col_l = r_col_a;
            col_r = col_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fctl.emit) begin
            r_col_a <= r_col_b;
        end
        if (r_fctl.emit || r_fctl.pre) begin
            r_col_b <= col_n;
        end
        for (int r = 0; r < WIN_SIZE; r++) begin
            r_win[r*WIN_SIZE]     <= col_l[r];
            r_win[r*WIN_SIZE + 1] <= r_col_b[r];
            r_win[r*WIN_SIZE + 2] <= col_r[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_ctl <= '0;
        end else begin
            r_win_ctl.valid <= r_fctl.emit;
            r_win_ctl.last  <= r_fctl.last;
        end
    end

    // ------------------------------------------------------------------
    // Sort chain: nine transposition cells leave the window fully sorted.
    // ------------------------------------------------------------------
    t_cell_ctl chain_ctl  [WIN_COUNT+1];
    t_win      chain_data [WIN_COUNT+1];

    assign chain_ctl[0]  = r_win_ctl;
    assign chain_data[0] = r_win;

    for (genvar c = 0; c < WIN_COUNT; c++) begin : g_cell
        imf_sort_cell #(
            .PHASE (c % 2)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chain_ctl[c]),
            .i_data  (chain_data[c]),
            .o_ctl   (chain_ctl[c+1]),
            .o_data  (chain_data[c+1])
        );
    end

    // ------------------------------------------------------------------
    // Output queue. r_pending counts results promised at the input and not
    // yet taken, so the queue can never overflow.
    // ------------------------------------------------------------------
    t_out                r_fifo [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]       r_count;
    logic                fifo_wr, out_acc;
    t_out                fifo_in;

    assign fifo_wr     = chain_ctl[WIN_COUNT].valid;
    assign fifo_in.pix = chain_data[WIN_COUNT][WIN_MID];
    assign fifo_in.last = chain_ctl[WIN_COUNT].last;
    assign out_acc     = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (fifo_wr) begin
            r_fifo[r_wr_ptr] <= fifo_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_pending <= '0;
        end else begin
            if (fifo_wr) begin
                r_wr_ptr <= r_wr_ptr + OFIFO_AW'(1);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + OFIFO_AW'(1);
            end
            r_count   <= r_count + (fifo_wr ? CW'(1) : CW'(0))
                                 - (out_acc ? CW'(1) : CW'(0));
            r_pending <= r_pending + (emit ? CW'(1) : CW'(0))
                                   - (out_acc ? CW'(1) : CW'(0));
        end
    end

    assign o_in_stall  = (r_pending >= CW'(OFIFO_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_pixel_out = r_fifo[r_rd_ptr].pix;
    assign o_frame_end = r_fifo[r_rd_ptr].last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= CW'(OFIFO_DEPTH))
        else $error("results in flight exceed the output queue");

    a_count_le_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_pending)
        else $error("queue holds a result that was never promised");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_wr |-> (r_count < CW'(OFIFO_DEPTH) || out_acc))
        else $error("output queue written while full");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_pending != '0)
        else $error("released result not counted");

    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap <= lag)
        else $error("input runs too far ahead of the output position");

endmodule
